// ----- design/pcg_pkg.sv -----
// shared types and constants of the polyline curvature block
package pcg_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int CURV_WIDTH      = 32;
    // squared-magnitude quotient bits: curvature magnitude stays below 2^(CURV_WIDTH-1)
    localparam int QUO_BITS        = 2 * (CURV_WIDTH - 1);
    localparam int WIN_DEPTH       = 4;
    localparam int PTS             = WIN_DEPTH + 1;
    localparam logic [2:0] PTS_SAT = 3'd5;

    // window positions: center of a full window and newest point
    localparam logic [2:0] POS_CENTER = 3'd2;
    localparam logic [2:0] POS_NEWEST = 3'd4;

    localparam logic [CURV_WIDTH-1:0] SAT_POS = {1'b0, {(CURV_WIDTH-1){1'b1}}};
    localparam logic [CURV_WIDTH-1:0] SAT_NEG = {1'b1, {(CURV_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CALC,
        ST_EMIT,
        ST_UPDATE
    } t_item_st;

    typedef enum logic [3:0] {
        C_IDLE,
        C_M1,
        C_M2,
        C_NEG,
        C_SQN,
        C_SQQ1,
        C_SQQ2,
        C_Q2,
        C_Q3,
        C_CMP,
        C_DIV,
        C_SQRT,
        C_DONE
    } t_core_st;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

endpackage

// ----- design/polyline_curvature_gradient.sv -----
// top level of the streamed polyline curvature block, one point per request
// a point is taken only in idle; it runs up to three curvature jobs on the shared adder,
// one after another, each finishing sooner for short operands; the input stays held until
// the last job of the point is done and the window is updated; results wait in an output
// register, and a stall on it holds the block in its emit state
// synchronous active-low reset clears the window, point count and handshake state
module polyline_curvature_gradient #(
    parameter int COORD_WIDTH    = 32,
    parameter int CURV_FRAC_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic                          i_point_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_curvature,
    output logic                          o_curvature_last
);
    import pcg_pkg::*;

    t_item_st                      r_state, n_state;
    logic signed [COORD_WIDTH-1:0] r_x, n_x;
    logic signed [COORD_WIDTH-1:0] r_y, n_y;
    logic                          r_last, n_last;
    logic [2:0]                    r_g, n_g;
    logic [2:0]                    r_g_end, n_g_end;
    logic                          r_kick, n_kick;
    logic                          r_oval, n_oval;
    logic [CURV_WIDTH-1:0]         r_ocurv, n_ocurv;
    logic                          r_olast, n_olast;

    t_win_ctl                      win_ctl;
    logic [2:0]                    count;
    logic [2:0]                    hist;
    logic signed [COORD_WIDTH+1:0] dx, dy;
    logic signed [COORD_WIDTH+3:0] ex, ey;
    logic                          core_done;
    logic [CURV_WIDTH-1:0]         core_res;

    pcg_window #(.COORD_WIDTH(COORD_WIDTH)) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (win_ctl),
        .i_new_x (r_x),
        .i_new_y (r_y),
        .i_last  (r_last),
        .i_sel   (r_g),
        .o_count (count),
        .o_dx    (dx),
        .o_dy    (dy),
        .o_ex    (ex),
        .o_ey    (ey)
    );

    pcg_core #(
        .COORD_WIDTH    (COORD_WIDTH),
        .CURV_FRAC_BITS (CURV_FRAC_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_kick),
        .i_dx     (dx),
        .i_dy     (dy),
        .i_ex     (ex),
        .i_ey     (ey),
        .o_done   (core_done),
        .o_result (core_res)
    );

    // control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kick  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kick  <= n_kick;
            r_oval  <= n_oval;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_last  <= n_last;
        r_g     <= n_g;
        r_g_end <= n_g_end;
        r_ocurv <= n_ocurv;
        r_olast <= n_olast;
    end

    assign hist = (count >= 3'(WIN_DEPTH)) ? 3'(WIN_DEPTH) : count;

    // per-point sequencing over the pending window positions
    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_last  = r_last;
        n_g     = r_g;
        n_g_end = r_g_end;
        n_kick  = 1'b0;
        n_oval  = r_oval;
        n_ocurv = r_ocurv;
        n_olast = r_olast;
        win_ctl = '0;

        if (r_oval && i_ready) begin
            n_oval = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_x     = i_point_x;
                    n_y     = i_point_y;
                    n_last  = i_point_last;
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (r_last || count >= 3'd2) begin
                    n_g     = (count >= 3'd2) ? POS_CENTER : (3'(WIN_DEPTH) - hist);
                    n_g_end = r_last ? POS_NEWEST : POS_CENTER;
                    n_kick  = 1'b1;
                    n_state = ST_CALC;
                end else begin
                    n_state = ST_UPDATE;
                end
            end
            ST_CALC: begin
                if (core_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_oval || i_ready) begin
                    n_oval  = 1'b1;
                    n_ocurv = core_res;
                    n_olast = r_last && (r_g == POS_NEWEST);
                    if (r_g == r_g_end) begin
                        n_state = ST_UPDATE;
                    end else begin
                        n_g     = r_g + 3'd1;
                        n_kick  = 1'b1;
                        n_state = ST_CALC;
                    end
                end
            end
            ST_UPDATE: begin
                win_ctl.clear = r_last;
                win_ctl.shift = !r_last;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = r_oval;
    assign o_curvature      = r_ocurv;
    assign o_curvature_last = r_olast;

endmodule

// ----- design/pcg_window.sv -----
// point window and gradient terms for one selected window position
module pcg_window #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcg_pkg::t_win_ctl             i_ctl,
    input  logic signed [COORD_WIDTH-1:0] i_new_x,
    input  logic signed [COORD_WIDTH-1:0] i_new_y,
    input  logic                          i_last,
    input  logic [2:0]                    i_sel,
    output logic [2:0]                    o_count,
    output logic signed [COORD_WIDTH+1:0] o_dx,
    output logic signed [COORD_WIDTH+1:0] o_dy,
    output logic signed [COORD_WIDTH+3:0] o_ex,
    output logic signed [COORD_WIDTH+3:0] o_ey
);
    import pcg_pkg::*;

    localparam int DW = COORD_WIDTH + 2;
    localparam int EW = COORD_WIDTH + 4;

    logic signed [COORD_WIDTH-1:0] r_wx [WIN_DEPTH];
    logic signed [COORD_WIDTH-1:0] r_wy [WIN_DEPTH];
    logic [2:0]                    r_count;

    logic [2:0]          hist;
    logic [2:0]          first;
    logic                start;
    logic signed [DW-1:0] apx [PTS+2];
    logic signed [DW-1:0] apy [PTS+2];
    logic signed [DW-1:0] g1x [PTS];
    logic signed [DW-1:0] g1y [PTS];
    logic signed [EW-1:0] gpx [PTS+2];
    logic signed [EW-1:0] gpy [PTS+2];
    logic signed [EW-1:0] g2x [PTS];
    logic signed [EW-1:0] g2y [PTS];

    // window shift, clear after the final point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_count <= '0;
            for (int j = 0; j < WIN_DEPTH; j++) begin
                r_wx[j] <= '0;
                r_wy[j] <= '0;
            end
        end else if (i_ctl.shift) begin
            for (int j = 0; j < WIN_DEPTH - 1; j++) begin
                r_wx[j] <= r_wx[j+1];
                r_wy[j] <= r_wy[j+1];
            end
            r_wx[WIN_DEPTH-1] <= i_new_x;
            r_wy[WIN_DEPTH-1] <= i_new_y;
            r_count <= (r_count < PTS_SAT) ? r_count + 3'd1 : PTS_SAT;
        end
    end

    // first valid position and whether it opens the polyline
    always_comb begin
        hist  = (r_count >= 3'(WIN_DEPTH)) ? 3'(WIN_DEPTH) : r_count;
        first = 3'(WIN_DEPTH) - hist;
        start = (r_count <= 3'(WIN_DEPTH));
    end

    // padded point rows, the pads repeat the edge points
    always_comb begin
        for (int j = 0; j < WIN_DEPTH; j++) begin
            apx[j+1] = {{2{r_wx[j][COORD_WIDTH-1]}}, r_wx[j]};
            apy[j+1] = {{2{r_wy[j][COORD_WIDTH-1]}}, r_wy[j]};
        end
        apx[PTS] = {{2{i_new_x[COORD_WIDTH-1]}}, i_new_x};
        apy[PTS] = {{2{i_new_y[COORD_WIDTH-1]}}, i_new_y};
        apx[0]     = apx[1];
        apy[0]     = apy[1];
        apx[PTS+1] = apx[PTS];
        apy[PTS+1] = apy[PTS];
    end

    // doubled first derivatives
    always_comb begin
        for (int j = 0; j < PTS; j++) begin
            if (start && 3'(j) == first) begin
                g1x[j] = (apx[j+2] - apx[j+1]) <<< 1;
                g1y[j] = (apy[j+2] - apy[j+1]) <<< 1;
            end else if (i_last && j == PTS - 1) begin
                g1x[j] = (apx[j+1] - apx[j]) <<< 1;
                g1y[j] = (apy[j+1] - apy[j]) <<< 1;
            end else begin
                g1x[j] = apx[j+2] - apx[j];
                g1y[j] = apy[j+2] - apy[j];
            end
        end
    end

    // padded first-derivative rows
    always_comb begin
        for (int j = 0; j < PTS; j++) begin
            gpx[j+1] = {{2{g1x[j][DW-1]}}, g1x[j]};
            gpy[j+1] = {{2{g1y[j][DW-1]}}, g1y[j]};
        end
        gpx[0]     = gpx[1];
        gpy[0]     = gpy[1];
        gpx[PTS+1] = gpx[PTS];
        gpy[PTS+1] = gpy[PTS];
    end

    // quadrupled second derivatives
    always_comb begin
        for (int j = 0; j < PTS; j++) begin
            if (start && 3'(j) == first) begin
                g2x[j] = (gpx[j+2] - gpx[j+1]) <<< 1;
                g2y[j] = (gpy[j+2] - gpy[j+1]) <<< 1;
            end else if (i_last && j == PTS - 1) begin
                g2x[j] = (gpx[j+1] - gpx[j]) <<< 1;
                g2y[j] = (gpy[j+1] - gpy[j]) <<< 1;
            end else begin
                g2x[j] = gpx[j+2] - gpx[j];
                g2y[j] = gpy[j+2] - gpy[j];
            end
        end
    end

    assign o_count = r_count;
    assign o_dx    = g1x[i_sel];
    assign o_dy    = g1y[i_sel];
    assign o_ex    = g2x[i_sel];
    assign o_ey    = g2y[i_sel];

endmodule

// ----- design/pcg_alu.sv -----
// shared wide adder and subtractor with unsigned compare
module pcg_alu #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic             i_sub,
    output logic [WIDTH-1:0] o_sum,
    output logic             o_ge
);
    logic [WIDTH:0] full;

    // carry out of a - b is set when a >= b
    assign full  = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + {{WIDTH{1'b0}}, i_sub};
    assign o_sum = full[WIDTH-1:0];
    assign o_ge  = i_sub & full[WIDTH];

endmodule

// ----- design/pcg_core.sv -----
// curvature sequencer: shift-add products, restoring divide and square root on one adder
module pcg_core #(
    parameter int COORD_WIDTH    = 32,
    parameter int CURV_FRAC_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [COORD_WIDTH+1:0]       i_dx,
    input  logic signed [COORD_WIDTH+1:0]       i_dy,
    input  logic signed [COORD_WIDTH+3:0]       i_ex,
    input  logic signed [COORD_WIDTH+3:0]       i_ey,
    output logic                                o_done,
    output logic [pcg_pkg::CURV_WIDTH-1:0]      o_result
);
    import pcg_pkg::*;

    localparam int DW   = COORD_WIDTH + 2;
    localparam int EW   = COORD_WIDTH + 4;
    localparam int MW   = 2 * COORD_WIDTH + 5;
    localparam int QW   = 2 * COORD_WIDTH + 3;
    localparam int SH   = 2 * (COORD_FRAC_BITS + CURV_FRAC_BITS);
    localparam int PW   = 4 * COORD_WIDTH + 10 + SH;
    localparam int CW   = 6 * COORD_WIDTH + 9 + QUO_BITS;
    localparam int LW   = ((PW > CW) ? PW : CW) + 1;
    localparam int CNTW = $clog2(QUO_BITS);

    t_core_st               r_state, n_state;
    logic [LW-1:0]          r_acc, n_acc;
    logic [LW-1:0]          r_mcand, n_mcand;
    logic [MW-1:0]          r_mplier, n_mplier;
    logic                   r_neg, n_neg;
    logic [LW-1:0]          r_rem, n_rem;
    logic [LW-1:0]          r_div, n_div;
    logic [QW-1:0]          r_q, n_q;
    logic [QUO_BITS-1:0]    r_quo, n_quo;
    logic [QUO_BITS-1:0]    r_root, n_root;
    logic [QUO_BITS-1:0]    r_one, n_one;
    logic [CNTW-1:0]        r_cnt, n_cnt;
    logic [CURV_WIDTH-1:0]  r_res, n_res;

    logic [LW-1:0]          alu_a, alu_b, alu_sum;
    logic                   alu_sub, alu_ge;

    logic [DW-1:0]          dxu, dyu, dx_mag, dy_mag, dx_neg;
    logic [EW-1:0]          exu, eyu, ey_mag, ex_neg;
    logic [DW-1:0]          mc1;
    logic [EW-1:0]          mc2;
    logic [LW-1:0]          mul_acc, nval;
    logic                   mul_last;
    logic [QUO_BITS-1:0]    quo_v, root_v;
    logic [CURV_WIDTH-2:0]  mag;

    pcg_alu #(.WIDTH(LW)) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum),
        .o_ge  (alu_ge)
    );

    // magnitudes and signed multiplicands of the derivative terms
    always_comb begin
        dxu    = i_dx;
        dyu    = i_dy;
        exu    = i_ex;
        eyu    = i_ey;
        dx_neg = ~dxu + 1'b1;
        ex_neg = ~exu + 1'b1;
        dx_mag = dxu[DW-1] ? dx_neg : dxu;
        dy_mag = dyu[DW-1] ? (~dyu + 1'b1) : dyu;
        ey_mag = eyu[EW-1] ? (~eyu + 1'b1) : eyu;
        // dx*ey then -(ex*dy), each with a non-negative multiplier
        mc1    = eyu[EW-1] ? dx_neg : dxu;
        mc2    = dyu[DW-1] ? exu : ex_neg;
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_neg    <= n_neg;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_q      <= n_q;
        r_quo    <= n_quo;
        r_root   <= n_root;
        r_one    <= n_one;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
    end

    // sequencer; derivative inputs hold still while it runs
    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_neg    = r_neg;
        n_rem    = r_rem;
        n_div    = r_div;
        n_q      = r_q;
        n_quo    = r_quo;
        n_root   = r_root;
        n_one    = r_one;
        n_cnt    = r_cnt;
        n_res    = r_res;
        o_done   = 1'b0;
        alu_a    = r_acc;
        alu_b    = r_mcand;
        alu_sub  = 1'b0;
        mul_acc  = r_mplier[0] ? alu_sum : r_acc;
        mul_last = (r_mplier[MW-1:1] == '0);
        nval     = r_acc;
        quo_v    = r_quo;
        root_v   = r_root;
        mag      = '0;

        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    if (dxu == '0 || dyu == '0) begin
                        n_res   = '0;
                        n_state = C_DONE;
                    end else begin
                        n_acc    = '0;
                        n_mcand  = {{(LW-DW){mc1[DW-1]}}, mc1};
                        n_mplier = {{(MW-EW){1'b0}}, ey_mag};
                        n_state  = C_M1;
                    end
                end
            end
            C_M1: begin
                n_acc    = mul_acc;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                if (mul_last) begin
                    n_mcand  = {{(LW-EW){mc2[EW-1]}}, mc2};
                    n_mplier = {{(MW-DW){1'b0}}, dy_mag};
                    n_state  = C_M2;
                end
            end
            C_M2: begin
                n_acc    = mul_acc;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                if (mul_last) begin
                    n_state = C_NEG;
                end
            end
            C_NEG: begin
                // take the magnitude of the numerator
                alu_a    = '0;
                alu_b    = r_acc;
                alu_sub  = 1'b1;
                n_neg    = r_acc[LW-1];
                nval     = r_acc[LW-1] ? alu_sum : r_acc;
                n_mcand  = nval;
                n_mplier = nval[MW-1:0];
                n_acc    = '0;
                n_state  = C_SQN;
            end
            C_SQN: begin
                n_acc    = mul_acc;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                if (mul_last) begin
                    n_rem    = mul_acc << SH;
                    n_mcand  = {{(LW-DW){1'b0}}, dx_mag};
                    n_mplier = {{(MW-DW){1'b0}}, dx_mag};
                    n_acc    = '0;
                    n_state  = C_SQQ1;
                end
            end
            C_SQQ1: begin
                n_acc    = mul_acc;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                if (mul_last) begin
                    n_mcand  = {{(LW-DW){1'b0}}, dy_mag};
                    n_mplier = {{(MW-DW){1'b0}}, dy_mag};
                    n_state  = C_SQQ2;
                end
            end
            C_SQQ2: begin
                n_acc    = mul_acc;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                if (mul_last) begin
                    n_q      = mul_acc[QW-1:0];
                    n_mcand  = mul_acc;
                    n_mplier = {{(MW-QW){1'b0}}, mul_acc[QW-1:0]};
                    n_acc    = '0;
                    n_state  = C_Q2;
                end
            end
            C_Q2: begin
                n_acc    = mul_acc;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                if (mul_last) begin
                    n_mcand  = mul_acc;
                    n_mplier = {{(MW-QW){1'b0}}, r_q};
                    n_acc    = '0;
                    n_state  = C_Q3;
                end
            end
            C_Q3: begin
                n_acc    = mul_acc;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                if (mul_last) begin
                    n_div   = mul_acc << QUO_BITS;
                    n_state = C_CMP;
                end
            end
            C_CMP: begin
                // quotient too large for the output range
                alu_a   = r_rem;
                alu_b   = r_div;
                alu_sub = 1'b1;
                if (alu_ge) begin
                    n_res   = r_neg ? SAT_NEG : SAT_POS;
                    n_state = C_DONE;
                end else begin
                    n_div   = r_div >> 1;
                    n_quo   = '0;
                    n_cnt   = CNTW'(QUO_BITS - 1);
                    n_state = C_DIV;
                end
            end
            C_DIV: begin
                alu_a   = r_rem;
                alu_b   = r_div;
                alu_sub = 1'b1;
                if (alu_ge) begin
                    n_rem = alu_sum;
                end
                quo_v = {r_quo[QUO_BITS-2:0], alu_ge};
                n_quo = quo_v;
                n_div = r_div >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_rem   = {{(LW-QUO_BITS){1'b0}}, quo_v};
                    n_root  = '0;
                    n_one   = {2'b01, {(QUO_BITS-2){1'b0}}};
                    n_cnt   = CNTW'(QUO_BITS / 2 - 1);
                    n_state = C_SQRT;
                end
            end
            C_SQRT: begin
                alu_a   = r_rem;
                alu_b   = {{(LW-QUO_BITS){1'b0}}, (r_root | r_one)};
                alu_sub = 1'b1;
                if (alu_ge) begin
                    n_rem  = alu_sum;
                    root_v = (r_root >> 1) | r_one;
                end else begin
                    root_v = r_root >> 1;
                end
                n_root = root_v;
                n_one  = r_one >> 2;
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    mag     = root_v[CURV_WIDTH-2:0];
                    n_res   = r_neg ? ({CURV_WIDTH{1'b0}} - {1'b0, mag}) : {1'b0, mag};
                    n_state = C_DONE;
                end
            end
            C_DONE: begin
                o_done  = 1'b1;
                n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    assign o_result = r_res;

endmodule

// ----- design/pcg_checker.sv -----
// port-level checks of the curvature block and their binding
module pcg_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_curvature,
    input logic        i_curvature_last
);

    // a taken point keeps the block busy
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready stayed high after a point was taken");

    // reset leaves the block idle with no pending result
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in_ready && !i_out_valid))
        else $error("block not idle after reset");

    // a new result appears only while a point is in work
    a_result_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !i_in_ready)
        else $error("result appeared while idle");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_curvature) && $stable(i_curvature_last)))
        else $error("stalled result changed");

endmodule

bind polyline_curvature_gradient pcg_props u_pcg_props (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_valid),
    .i_in_ready       (o_ready),
    .i_out_valid      (o_valid),
    .i_out_ready      (i_ready),
    .i_curvature      (o_curvature),
    .i_curvature_last (o_curvature_last)
);

// ----- tb/pcg_checker.sv -----
// request monitor, curvature predictor and result comparison for the polyline block
`timescale 1ns / 1ps
module pcg_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_o_ready,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic               i_point_last,
    input  logic               i_o_valid,
    input  logic               i_ready,
    input  logic signed [31:0] i_curvature,
    input  logic               i_curvature_last,
    output int                 o_fail_count,
    output int                 o_pending
);
    import pcg_pkg::*;

    typedef longint t_pts [PTS];
    typedef logic [511:0] t_wide;
    typedef struct {
        logic [31:0] curv;
        logic        last;
    } t_curv_res;

    localparam int SHIFT = COORD_FRAC_BITS + 24;

    t_curv_res curv_q[$];
    longint    hist_x [WIN_DEPTH];
    longint    hist_y [WIN_DEPTH];
    int        n_pts;
    int        fails;

    assign o_fail_count = fails;
    assign o_pending    = curv_q.size();

    // point k of the local window, zero outside it
    function automatic longint pt_at(t_pts p, int m, int k);
        if (k < 0 || k >= m) return 0;
        return p[k];
    endfunction

    // first derivative times two
    function automatic longint slope2(t_pts p, int m, bit st, bit en, int k);
        if (k == 0 && st) return 2 * (pt_at(p, m, 1) - pt_at(p, m, 0));
        if (k == m - 1 && en) return 2 * (pt_at(p, m, k) - pt_at(p, m, k - 1));
        return pt_at(p, m, k + 1) - pt_at(p, m, k - 1);
    endfunction

    // second derivative times four
    function automatic longint bend4(t_pts p, int m, bit st, bit en, int k);
        if (k == 0 && st)
            return 2 * (slope2(p, m, st, en, 1) - slope2(p, m, st, en, 0));
        if (k == m - 1 && en)
            return 2 * (slope2(p, m, st, en, k) - slope2(p, m, st, en, k - 1));
        return slope2(p, m, st, en, k + 1) - slope2(p, m, st, en, k - 1);
    endfunction

    // exact curvature, truncated toward zero and saturated
    function automatic logic [31:0] curvature_at(t_pts px, t_pts py, int m, bit st,
                                                 bit en, int k);
        logic signed [127:0] dx, dy, ex, ey, num, q;
        logic [63:0] mag, cand;
        t_wide m2, q3, prod;
        bit neg;
        dx = slope2(px, m, st, en, k);
        dy = slope2(py, m, st, en, k);
        ex = bend4(px, m, st, en, k);
        ey = bend4(py, m, st, en, k);
        if (dx == 0 || dy == 0 || m < 2) return '0;
        num = dx * ey - ex * dy;
        neg = num < 0;
        if (neg) num = -num;
        m2 = t_wide'(num) << SHIFT;
        m2 = m2 * m2;
        q = dx * dx + dy * dy;
        q3 = t_wide'(q);
        q3 = q3 * q3 * t_wide'(q);
        // largest magnitude whose square times q^3 stays within m2
        mag = '0;
        for (int b = 31; b >= 0; b--) begin
            cand = mag | (64'd1 << b);
            prod = t_wide'(cand) * t_wide'(cand) * q3;
            if (prod <= m2) mag = cand;
        end
        if (!neg) return (mag > 64'h7FFF_FFFF) ? SAT_POS : mag[31:0];
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        return 32'(-mag);
    endfunction

    // append one expected result at the tail of the queue
    function automatic void add_expected(logic [31:0] curv, logic last);
        t_curv_res r;
        r.curv = curv;
        r.last = last;
        curv_q.insert(curv_q.size(), r);
    endfunction

    // predict the results of one accepted point
    task automatic predict_point(longint x, longint y, bit last);
        t_pts px, py;
        int c, hist, m, k;
        bit st;
        c = n_pts;
        hist = (c < WIN_DEPTH) ? c : WIN_DEPTH;
        m = hist + 1;
        st = c <= WIN_DEPTH;
        for (int i = 0; i < PTS; i++) begin
            px[i] = 0;
            py[i] = 0;
        end
        for (int i = 0; i < hist; i++) begin
            px[i] = hist_x[WIN_DEPTH - hist + i];
            py[i] = hist_y[WIN_DEPTH - hist + i];
        end
        px[hist] = x;
        py[hist] = y;
        if (last) begin
            for (k = (m >= 3) ? m - 3 : 0; k < m; k++)
                add_expected((m == 1) ? 32'd0 : curvature_at(px, py, m, st, 1'b1, k),
                             k == m - 1);
            for (int i = 0; i < WIN_DEPTH; i++) begin
                hist_x[i] = 0;
                hist_y[i] = 0;
            end
            n_pts = 0;
        end else begin
            if (c >= 2)
                add_expected(curvature_at(px, py, m, st, 1'b0, m - 3), 1'b0);
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                hist_x[i] = hist_x[i + 1];
                hist_y[i] = hist_y[i + 1];
            end
            hist_x[WIN_DEPTH - 1] = x;
            hist_y[WIN_DEPTH - 1] = y;
            n_pts = (c < 5) ? c + 1 : 5;
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        t_curv_res exp_res;
        if (!i_rst_n) begin
            curv_q.delete();
            for (int i = 0; i < WIN_DEPTH; i++) begin
                hist_x[i] = 0;
                hist_y[i] = 0;
            end
            n_pts = 0;
            fails = 0;
        end else begin
            if (i_valid && i_o_ready)
                predict_point(longint'(i_point_x), longint'(i_point_y), i_point_last);
            if (i_o_valid && i_ready) begin
                if (curv_q.size() == 0) begin
                    $error("unexpected result: curvature %0d last %0d",
                           i_curvature, i_curvature_last);
                    fails++;
                end else begin
                    exp_res = curv_q.pop_front();
                    if (i_curvature !== exp_res.curv) begin
                        $error("curvature: expected %0d, got %0d",
                               $signed(exp_res.curv), i_curvature);
                        fails++;
                    end
                    if (i_curvature_last !== exp_res.last) begin
                        $error("curvature_last: expected %0d, got %0d",
                               exp_res.last, i_curvature_last);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/tb_top.sv -----
// stimulus, clocking and verdict for the polyline curvature testbench
`timescale 1ns / 1ps
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1500;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic               i_point_last = 1'b0;
    logic               i_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic signed [31:0] o_curvature;
    logic               o_curvature_last;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct = 13;
    int                 recv_idle_pct = 45;
    int                 idle_cycles = 0;
    int                 n_sent = 0;

    polyline_curvature_gradient dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_last(i_point_last),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_curvature(o_curvature), .o_curvature_last(o_curvature_last)
    );

    pcg_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_o_ready(o_ready),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_last(i_point_last),
        .i_o_valid(o_valid), .i_ready(i_ready),
        .i_curvature(o_curvature), .i_curvature_last(o_curvature_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #6 i_clk = ~i_clk;

    // random stall on the result side
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no request accepted on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one point request, returns at the accepting edge
    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_point_x = x;
        i_point_y = y;
        i_point_last = last;
        do @(posedge i_clk); while (!o_ready);
        n_sent++;
    endtask

    // hold off until every pending curvature has come out
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // wide-range random coordinate with extremes mixed in
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(2000)) - 1000;
            default: return $signed($urandom());
        endcase
    endfunction

    // polyline of n points; shape 0 random, 1 smooth arc, 2 axis-aligned
    task automatic send_polyline(int n, int shape);
        logic signed [31:0] x, y, sx, sy, turn;
        x = $signed($urandom());
        y = $signed($urandom());
        sx = $signed($urandom_range(200000)) - 100000;
        sy = $signed($urandom_range(200000)) - 100000;
        turn = $signed($urandom_range(4000)) - 2000;
        for (int i = 0; i < n; i++) begin
            case (shape)
                0: send_point(rand_coord(), rand_coord(), i == n - 1);
                1: begin
                    send_point(x, y, i == n - 1);
                    x = x + sx;
                    y = y + sy;
                    sx = sx - turn;
                    sy = sy + turn;
                end
                default: begin
                    send_point(x, y, i == n - 1);
                    if ($urandom_range(1)) x = x + sx;
                    else y = y + sy;
                end
            endcase
        end
    endtask

    initial begin
        int shape;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // single-point polylines at both extremes
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        send_point(32'sh8000_0000, 32'sh8000_0000, 1'b1);
        // two-point polyline
        send_point(32'sd100, 32'sd5, 1'b0);
        send_point(-32'sd300, 32'sd900, 1'b1);
        // three points on a tight left turn, then a tight right turn
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(32'sd1, 32'sd0, 1'b0);
        send_point(32'sd1, 32'sd1, 1'b1);
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(32'sd0, 32'sd1, 1'b0);
        send_point(32'sd1, 32'sd1, 1'b1);
        // alternating extremes over a long polyline
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_point(-32'sd1, 32'sd0, 1'b1);
        // horizontal run: zero y derivative everywhere
        for (int i = 0; i < 5; i++) send_point(32'(i * 65536), 32'sd7, i == 4);
        // gentle arc, moderate curvature
        send_polyline(4, 1);

        // random polylines in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 45 : 0;
            recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 13 : 0;
            while (n_sent < 25 + 45 * (phase + 1)) begin
                shape = $urandom_range(9);
                send_polyline($urandom_range(1, 9),
                              (shape < 5) ? 1 : (shape < 8) ? 0 : 2);
            end
            drain_results();
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
